/* rtl/core/mcpf_pkg.sv */
package mcpf_pkg;

   // field widths
   localparam int ByteWidth = 8;
   localparam int WordWidth = 32;
   localparam int CrcWidth  = 16;
   localparam int IdxWidth  = 5;
   localparam int SelWidth  = 3;

   // packet kinds
   typedef enum logic [1:0] {
      MODE_SPEED    = 2'd0,
      MODE_ENCODER  = 2'd1,
      MODE_POSITION = 2'd2,
      MODE_NONE     = 2'd3
   } mode_type;

   // position selector codes
   localparam logic [SelWidth-1:0] SEL_STEP   = 3'd5;
   localparam logic [SelWidth-1:0] SEL_OFFSET = 3'd6;

   // register indexes
   localparam logic [1:0] CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_INDEX_STEP     = 2'd1;
   localparam logic [1:0] CSR_INDEX_OFFSET   = 2'd2;

   // register reset values
   localparam logic [ByteWidth-1:0] DEVICE_ADDRESS_RESET = 8'd128;
   localparam logic [WordWidth-1:0] INDEX_STEP_RESET     = 32'hFFFF_F448;
   localparam logic [WordWidth-1:0] INDEX_OFFSET_RESET   = 32'hFFFF_F7EC;

   // packet layout
   localparam logic [IdxWidth-1:0]  LEN_SPEED       = 5'd5;
   localparam logic [IdxWidth-1:0]  LEN_ENCODER     = 5'd8;
   localparam logic [IdxWidth-1:0]  LEN_POSITION    = 5'd21;
   localparam logic [IdxWidth-1:0]  ENCODER_BASE    = 5'd2;
   localparam logic [IdxWidth-1:0]  POSITION_BASE   = 5'd14;
   localparam logic [IdxWidth-1:0]  BUFFER_IDX      = 5'd18;
   localparam logic [ByteWidth-1:0] BUFFER_BYTE     = 8'h01;
   localparam logic [ByteWidth-1:0] SPEED_MAX       = 8'd127;
   localparam logic [CrcWidth-1:0]  CRC_POLY        = 16'h1021;

   // one packet waiting to be sent
   typedef struct packed {
      mode_type               mode;
      logic [ByteWidth-1:0]   address;
      logic [ByteWidth-1:0]   command;
      logic [WordWidth-1:0]   payload;
   } frame_type;

   // byte offered by the emitter
   typedef struct packed {
      logic                   valid;
      logic                   last;
      logic [ByteWidth-1:0]   data;
   } emit_type;

   // fixed pot positions
   function automatic logic [WordWidth-1:0] fixed_position(input logic [SelWidth-1:0] sel);
      logic [WordWidth-1:0] pos;
      case (sel)
         3'd1:    pos = 32'd1000;
         3'd2:    pos = 32'd2000;
         3'd3:    pos = 32'd3000;
         3'd4:    pos = 32'd4000;
         default: pos = '0;
      endcase
      return pos;
   endfunction

   // speed clamped to 0..127
   function automatic logic [ByteWidth-1:0] clamp_speed(input logic [WordWidth-1:0] value);
      logic [ByteWidth-1:0] spd;
      if (value[WordWidth-1]) begin
         spd = '0;
      end else if (|value[WordWidth-2:7]) begin
         spd = SPEED_MAX;
      end else begin
         spd = {1'b0, value[6:0]};
      end
      return spd;
   endfunction

   // packet length per kind
   function automatic logic [IdxWidth-1:0] frame_length(input mode_type mode);
      logic [IdxWidth-1:0] len;
      case (mode)
         MODE_SPEED:   len = LEN_SPEED;
         MODE_ENCODER: len = LEN_ENCODER;
         default:      len = LEN_POSITION;
      endcase
      return len;
   endfunction

   // crc-16/xmodem over one byte, msb first
   function automatic logic [CrcWidth-1:0] crc16_byte(input logic [CrcWidth-1:0] crc_in,
                                                      input logic [ByteWidth-1:0] data);
      logic [CrcWidth-1:0] c;
      c = crc_in ^ {data, 8'h00};
      for (int k = 0; k < ByteWidth; k++) begin
         if (c[CrcWidth-1]) begin
            c = {c[CrcWidth-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CrcWidth-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* rtl/core/mcpf_emitter.sv */
module mcpf_emitter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  mcpf_pkg::frame_type  frame_in,
   input  logic                 advance,
   output logic                 can_load,
   output mcpf_pkg::emit_type   emit
);

   logic                              busy_ff, busy_in;
   logic [mcpf_pkg::IdxWidth-1:0]     idx_ff, idx_in;
   logic [mcpf_pkg::CrcWidth-1:0]     crc_ff, crc_in;
   mcpf_pkg::frame_type               frame_ff, frame_in_r;

   logic [mcpf_pkg::IdxWidth-1:0]     len;
   logic [mcpf_pkg::IdxWidth-1:0]     rel_idx;
   logic [1:0]                        byte_sel;
   logic [mcpf_pkg::ByteWidth-1:0]    payload_byte;
   logic [mcpf_pkg::ByteWidth-1:0]    body_byte;
   logic [mcpf_pkg::ByteWidth-1:0]    byte_now;
   logic                              last_now;
   logic                              step;

   // frame length and position of the current byte
   assign len      = mcpf_pkg::frame_length(frame_ff.mode);
   assign last_now = (idx_ff == len - 5'd1);
   assign step     = busy_ff && advance;
   assign can_load = !busy_ff || (step && last_now);

   // big-endian word byte picked relative to the word start
   always_comb begin
      if (frame_ff.mode == mcpf_pkg::MODE_ENCODER) begin
         rel_idx = idx_ff - mcpf_pkg::ENCODER_BASE;
      end else begin
         rel_idx = idx_ff - mcpf_pkg::POSITION_BASE;
      end
      byte_sel = rel_idx[1:0];
      case (byte_sel)
         2'd0:    payload_byte = frame_ff.payload[31:24];
         2'd1:    payload_byte = frame_ff.payload[23:16];
         2'd2:    payload_byte = frame_ff.payload[15:8];
         default: payload_byte = frame_ff.payload[7:0];
      endcase
   end

   // body byte by packet kind
   always_comb begin
      case (frame_ff.mode)
         mcpf_pkg::MODE_SPEED: begin
            body_byte = frame_ff.payload[7:0];
         end
         mcpf_pkg::MODE_ENCODER: begin
            body_byte = payload_byte;
         end
         default: begin
            if (idx_ff == mcpf_pkg::BUFFER_IDX) begin
               body_byte = mcpf_pkg::BUFFER_BYTE;
            end else if (idx_ff >= mcpf_pkg::POSITION_BASE) begin
               body_byte = payload_byte;
            end else begin
               body_byte = '0;
            end
         end
      endcase
   end

   // header, body or crc
   always_comb begin
      if (idx_ff == 5'd0) begin
         byte_now = frame_ff.address;
      end else if (idx_ff == 5'd1) begin
         byte_now = frame_ff.command;
      end else if (last_now) begin
         byte_now = crc_ff[7:0];
      end else if (idx_ff == len - 5'd2) begin
         byte_now = crc_ff[15:8];
      end else begin
         byte_now = body_byte;
      end
   end

   assign emit.valid = busy_ff;
   assign emit.last  = last_now;
   assign emit.data  = byte_now;

   // next state
   always_comb begin
      busy_in    = busy_ff;
      idx_in     = idx_ff;
      crc_in     = crc_ff;
      frame_in_r = frame_ff;
      if (step) begin
         idx_in = idx_ff + 5'd1;
         // crc covers address through body, not its own two bytes
         if (idx_ff < len - 5'd2) begin
            crc_in = mcpf_pkg::crc16_byte(crc_ff, byte_now);
         end
         if (last_now) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in    = 1'b1;
         idx_in     = '0;
         crc_in     = '0;
         frame_in_r = frame_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      crc_ff   <= crc_in;
      frame_ff <= frame_in_r;
   end

   // byte index stays inside the packet
   a_idx_in_frame: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff < len))
      else $error("byte index past end of packet");

   // a new packet only replaces a finished one
   a_load_allowed: assert property (@(posedge clock) disable iff (reset)
      load |-> can_load)
      else $error("packet loaded over one still being sent");

   // a load always starts at the address byte
   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      load |=> (busy_ff && idx_ff == 5'd0))
      else $error("loaded packet did not start at first byte");

endmodule

/* rtl/core/motor_command_packet_framer.sv */
// Motor command packet framer. Each request (mode, command, value, position
// selector) becomes one serial packet sent one byte per response: address,
// command, body, then CRC-16/XMODEM high byte first, with tlast on the CRC low
// byte. A speed packet is 5 bytes long, a set-encoder packet 8 and a position
// packet 21; the byte emitter sends exactly one byte per clock while the
// response side takes them. The next request is accepted in the cycle the
// last byte of the current packet moves into the output register, so packets
// follow each other with no gap. Mode 3 requests are taken and dropped. In
// position requests, step and offset selectors move the indexing position
// on accept. Registers should only be written while no packet is in flight.
module motor_command_packet_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // command[7:0], value[39:8]
   input  logic [4:0]  req_tuser,   // mode[1:0], position_select[4:2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // tx_byte[7:0]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [mcpf_pkg::ByteWidth-1:0] device_address_ff, device_address_in;
   logic [mcpf_pkg::WordWidth-1:0] index_step_ff, index_step_in;
   logic [mcpf_pkg::WordWidth-1:0] index_offset_ff, index_offset_in;
   logic [mcpf_pkg::WordWidth-1:0] index_position_ff, index_position_in;
   logic                           rsp_tvalid_ff, rsp_tvalid_in;
   logic [mcpf_pkg::ByteWidth-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                           rsp_tlast_ff, rsp_tlast_in;

   mcpf_pkg::mode_type             req_mode;
   logic [mcpf_pkg::SelWidth-1:0]  req_select;
   logic [mcpf_pkg::ByteWidth-1:0] req_command;
   logic [mcpf_pkg::WordWidth-1:0] req_value;
   logic                           req_accept;
   logic                           index_update;
   logic [mcpf_pkg::WordWidth-1:0] pos_add;
   logic [mcpf_pkg::WordWidth-1:0] pos_sum;
   logic [mcpf_pkg::WordWidth-1:0] position;
   logic                           load;
   logic                           out_ready;
   logic                           can_load;
   mcpf_pkg::frame_type            frame;
   mcpf_pkg::emit_type             emit;

   // request fields
   assign req_mode    = mcpf_pkg::mode_type'(req_tuser[1:0]);
   assign req_select  = req_tuser[4:2];
   assign req_command = req_tdata[7:0];
   assign req_value   = req_tdata[39:8];
   assign req_tready  = can_load;
   assign req_accept  = req_tvalid && req_tready;
   assign load        = req_accept && (req_mode != mcpf_pkg::MODE_NONE);

   // indexing position arithmetic
   assign index_update = load && (req_mode == mcpf_pkg::MODE_POSITION) &&
                         ((req_select == mcpf_pkg::SEL_STEP) ||
                          (req_select == mcpf_pkg::SEL_OFFSET));
   assign pos_add = (req_select == mcpf_pkg::SEL_STEP) ? index_step_ff : index_offset_ff;
   assign pos_sum = index_position_ff + pos_add;

   // position to send
   always_comb begin
      if (req_select < mcpf_pkg::SEL_STEP) begin
         position = mcpf_pkg::fixed_position(req_select);
      end else if ((req_select == mcpf_pkg::SEL_STEP) ||
                   (req_select == mcpf_pkg::SEL_OFFSET)) begin
         position = pos_sum;
      end else begin
         position = '0;
      end
   end

   // packet handed to the emitter
   always_comb begin
      frame.mode    = req_mode;
      frame.address = device_address_ff;
      frame.command = req_command;
      case (req_mode)
         mcpf_pkg::MODE_SPEED:    frame.payload = {24'd0, mcpf_pkg::clamp_speed(req_value)};
         mcpf_pkg::MODE_ENCODER:  frame.payload = req_value;
         mcpf_pkg::MODE_POSITION: frame.payload = position;
         default:                 frame.payload = req_value;
      endcase
   end

   mcpf_emitter u_emitter (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .frame_in (frame),
      .advance  (out_ready),
      .can_load (can_load),
      .emit     (emit)
   );

   // config and indexing position
   always_comb begin
      device_address_in = device_address_ff;
      index_step_in     = index_step_ff;
      index_offset_in   = index_offset_ff;
      index_position_in = index_position_ff;
      if (csr_we) begin
         case (csr_index)
            mcpf_pkg::CSR_DEVICE_ADDRESS: device_address_in = csr_wdata[7:0];
            mcpf_pkg::CSR_INDEX_STEP:     index_step_in     = csr_wdata;
            mcpf_pkg::CSR_INDEX_OFFSET:   index_offset_in   = csr_wdata;
            default: ;
         endcase
      end
      if (index_update) begin
         index_position_in = pos_sum;
      end
   end

   // output register
   assign out_ready = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (out_ready) begin
         rsp_tvalid_in = emit.valid;
         rsp_tdata_in  = emit.data;
         rsp_tlast_in  = emit.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= mcpf_pkg::DEVICE_ADDRESS_RESET;
         index_step_ff     <= mcpf_pkg::INDEX_STEP_RESET;
         index_offset_ff   <= mcpf_pkg::INDEX_OFFSET_RESET;
         index_position_ff <= '0;
         rsp_tvalid_ff     <= 1'b0;
      end else begin
         device_address_ff <= device_address_in;
         index_step_ff     <= index_step_in;
         index_offset_ff   <= index_offset_in;
         index_position_ff <= index_position_in;
         rsp_tvalid_ff     <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // indexing position moves only on step or offset requests
   a_index_hold: assert property (@(posedge clock) disable iff (reset)
      !index_update |=> $stable(index_position_ff))
      else $error("indexing position changed without a step or offset request");

   // every framed request starts a packet with the address byte
   a_packet_starts: assert property (@(posedge clock) disable iff (reset)
      load |=> (emit.valid && !emit.last && emit.data == $past(device_address_ff)))
      else $error("packet did not start with device address");

   // a dropped request leaves the emitter idle
   a_drop_idle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_mode == mcpf_pkg::MODE_NONE && !emit.valid) |=> !emit.valid)
      else $error("unused mode produced output");

endmodule
